/* rtl/core/lmbp_pkg.sv */
// shared types and codes for the load-module block parser
package lmbp_pkg;

    localparam logic [3:0] PH_TYPE    = 4'd0;
    localparam logic [3:0] PH_SIZE    = 4'd1;
    localparam logic [3:0] PH_ADDR_LO = 4'd2;
    localparam logic [3:0] PH_ADDR_HI = 4'd3;
    localparam logic [3:0] PH_DATA    = 4'd4;
    localparam logic [3:0] PH_E_SKIP  = 4'd5;
    localparam logic [3:0] PH_E_LO    = 4'd6;
    localparam logic [3:0] PH_E_HI    = 4'd7;
    localparam logic [3:0] PH_SKIPLEN = 4'd8;
    localparam logic [3:0] PH_SKIP    = 4'd9;
    localparam logic [3:0] PH_DRAIN   = 4'd10;

    localparam logic [7:0] BLK_END   = 8'h00;
    localparam logic [7:0] BLK_DATA  = 8'h01;
    localparam logic [7:0] BLK_ENTRY = 8'h02;

    localparam logic [8:0] SIZE_BASE  = 9'd254;
    localparam logic [8:0] SIZE_BIAS  = 9'd2;
    localparam logic [8:0] SKIP_FULL  = 9'd256;

    typedef struct packed {
        logic [3:0]  phase;
        logic [8:0]  remaining;
        logic [15:0] wr_addr;
        logic [7:0]  entry_low;
    } t_state;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic        load_done;
        logic [15:0] entry_address;
    } t_result;

endpackage

/* rtl/core/lmbp_if.sv */
// valid/ready channels for file bytes in and parse results out
interface lmbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface lmbp_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic        load_done;
    logic [15:0] entry_address;

    modport source (output valid, output write_valid, output mem_address, output mem_data,
                    output load_done, output entry_address, input ready);
    modport sink   (input valid, input write_valid, input mem_address, input mem_data,
                    input load_done, input entry_address, output ready);
endinterface

/* rtl/core/lmbp_step.sv */
// per-byte record decode: next parser state and the result for one word
module lmbp_step (
    input  lmbp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_eof,
    output lmbp_pkg::t_state  o_state,
    output lmbp_pkg::t_result o_result,
    output logic              o_emit
);
    import lmbp_pkg::*;

    logic        wr;
    logic        done;
    logic [15:0] entry;
    logic        eof_ends;
    logic [8:0]  rem_dec;

    assign rem_dec = i_state.remaining - 9'd1;

    always_comb begin
        o_state  = i_state;
        wr       = 1'b0;
        done     = 1'b0;
        entry    = '0;
        eof_ends = 1'b1;
        unique case (i_state.phase)
            PH_SIZE: begin
                if (i_byte <= 8'd2) begin
                    o_state.remaining = SIZE_BASE + {1'b0, i_byte};
                end else begin
                    o_state.remaining = {1'b0, i_byte} - SIZE_BIAS;
                end
                o_state.phase = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
                o_state.wr_addr[7:0] = i_byte;
                o_state.phase        = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
                o_state.wr_addr[15:8] = i_byte;
                o_state.phase = (i_state.remaining != '0) ? PH_DATA : PH_TYPE;
            end
            PH_DATA: begin
                wr                  = 1'b1;
                o_state.wr_addr     = i_state.wr_addr + 16'd1;
                o_state.remaining   = rem_dec;
                o_state.phase       = (rem_dec == '0) ? PH_TYPE : PH_DATA;
            end
            PH_E_SKIP: begin
                o_state.phase = PH_E_LO;
            end
            PH_E_LO: begin
                o_state.entry_low = i_byte;
                o_state.phase     = PH_E_HI;
            end
            PH_E_HI: begin
                // transfer record keeps its entry even when the flag is on this byte
                done          = 1'b1;
                entry         = {i_byte, i_state.entry_low};
                eof_ends      = 1'b0;
                o_state.phase = i_eof ? PH_TYPE : PH_DRAIN;
            end
            PH_SKIPLEN: begin
                o_state.remaining = (i_byte != '0) ? {1'b0, i_byte} : SKIP_FULL;
                o_state.phase     = PH_SKIP;
            end
            PH_SKIP: begin
                o_state.remaining = rem_dec;
                o_state.phase     = (rem_dec == '0) ? PH_TYPE : PH_SKIP;
            end
            PH_DRAIN: begin
                eof_ends      = 1'b0;
                o_state.phase = i_eof ? PH_TYPE : PH_DRAIN;
            end
            default: begin
                // unused phase codes parse as a block type
                priority if (i_byte == BLK_END) begin
                    done          = 1'b1;
                    eof_ends      = 1'b0;
                    o_state.phase = i_eof ? PH_TYPE : PH_DRAIN;
                end else if (i_byte == BLK_DATA) begin
                    o_state.phase = PH_SIZE;
                end else if (i_byte == BLK_ENTRY) begin
                    o_state.phase = PH_E_SKIP;
                end else begin
                    o_state.phase = PH_SKIPLEN;
                end
            end
        endcase

        // truncated file or end at a record boundary
        if (eof_ends && i_eof) begin
            done          = 1'b1;
            entry         = '0;
            o_state.phase = PH_TYPE;
        end

        o_result.write_valid   = wr;
        o_result.mem_address   = wr ? i_state.wr_addr : '0;
        o_result.mem_data      = wr ? i_byte : '0;
        o_result.load_done     = done;
        o_result.entry_address = done ? entry : '0;
        o_emit                 = wr | done;
    end

endmodule

/* rtl/core/load_module_block_parser_unit.sv */
// top level of the load-module block parser
// Takes one file byte per clock and gives at most one result word per byte, in the
// cycle after the byte is accepted: a memory write for each data byte of a data
// record, and a load-done word carrying the entry address (0 when the file ends
// without a transfer record). The parser state updates in the cycle a byte is
// accepted and the result sits in a single output register, so a byte is taken
// in every cycle in which that register is empty or being drained. After a load
// ends, bytes up to and including the one flagged as end of file give no result.
// There is no startup pass after reset.
module load_module_block_parser_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lmbp_in_if.sink          i_in,
    lmbp_out_if.source       o_out
);
    import lmbp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    n_emit;
    logic    in_take;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    lmbp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_in.file_byte),
        .i_eof    (i_in.end_of_file),
        .o_state  (n_state),
        .o_result (n_result),
        .o_emit   (n_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_TYPE, remaining: '0, wr_addr: '0, entry_low: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            if (in_take) begin
                r_out_valid <= n_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (in_take && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.write_valid   = r_result.write_valid;
    assign o_out.mem_address   = r_result.mem_address;
    assign o_out.mem_data      = r_result.mem_data;
    assign o_out.load_done     = r_result.load_done;
    assign o_out.entry_address = r_result.entry_address;

`ifndef NO_ASSERTIONS
    a_word_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.write_valid || o_out.load_done))
        else $error("result word with neither write nor done");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.write_valid) |-> (o_out.mem_address == '0 && o_out.mem_data == '0))
        else $error("write fields not cleared on a done-only word");

    a_eof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.end_of_file) |=> (r_state.phase == PH_TYPE))
        else $error("parser did not return to block type after end of file");

    a_drain_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && r_state.phase == PH_DRAIN) |=> !o_out.valid)
        else $error("result produced while draining to end of file");
`endif

endmodule
